[design/mwc_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Multiply-with-carry generator package
// Shared types, command and status structures and the fixed constants of the
// lag-4 multiply-with-carry generator.
// ----------------------------------------------------------------------------
package mwc_pkg;

  typedef enum logic [1:0] {
    MODE_RESEED = 2'd0,
    MODE_RAW    = 2'd1,
    MODE_RANGE  = 2'd2
  } mode_t;

  typedef enum logic [1:0] {
    MSRC_LAG   = 2'd0,
    MSRC_SEED  = 2'd1,
    MSRC_RANGE = 2'd2
  } mul_src_t;

  typedef enum logic [1:0] {
    ACC_HOLD  = 2'd0,
    ACC_CARRY = 2'd1,
    ACC_ADD   = 2'd2
  } acc_op_t;

  localparam logic [31:0] SEED_MUL    = 32'd29943829;
  localparam logic [31:0] ERROR_VALUE = 32'h8000_0000;
  localparam logic [2:0]  IDX_LAST    = 3'd4;

  typedef struct packed {
    logic     in_load;
    logic     mul_en;
    mul_src_t mul_src;
    logic [2:0] idx;
    acc_op_t  acc_op;
    logic     step_commit;
    logic     seed_wr;
    logic     out_load;
  } cmd_t;

  typedef struct packed {
    logic [1:0] mode;
    logic       range_bad;
    logic       out_free;
  } stat_t;

  // Lag word k (k = 0 newest) is weighted by this multiplier.
  function automatic logic [31:0] mul_term(input logic [1:0] k);
    logic [31:0] m;
    case (k)
      2'd0:    m = 32'd5115;
      2'd1:    m = 32'd1776;
      2'd2:    m = 32'd1492;
      default: m = 32'd2111111111;
    endcase
    return m;
  endfunction

endpackage

[design/mwc_req_if.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Request channel
// Valid/ready channel that carries one request beat: mode, seed and bounds.
// ----------------------------------------------------------------------------
interface mwc_req_if;
  logic               valid;
  logic               ready;
  logic [1:0]         mode;
  logic [31:0]        seed;
  logic signed [31:0] range_low;
  logic signed [31:0] range_high;

  modport source (output valid, output mode, output seed, output range_low,
                  output range_high, input ready);
  modport sink (input valid, input mode, input seed, input range_low,
                input range_high, output ready);
endinterface

[design/mwc_rsp_if.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Result channel
// Valid/ready channel that carries one result beat of the generator.
// ----------------------------------------------------------------------------
interface mwc_rsp_if;
  logic               valid;
  logic               ready;
  logic [31:0]        raw_word;
  logic signed [31:0] range_value;
  logic               range_error;

  modport source (output valid, output raw_word, output range_value,
                  output range_error, input ready);
  modport sink (input valid, input raw_word, input range_value,
                input range_error, output ready);
endinterface

[design/multiply_with_carry_rng.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Lag-4 multiply-with-carry random number generator
// Each generator step forms 2111111111*x[n-4] + 1492*x[n-3] + 1776*x[n-2] +
// 5115*x[n-1] + carry on one shared multiplier, one term per cycle. A raw
// draw runs one step and loads the result, and a range draw adds one more
// multiply for the scaling. A range draw with the upper bound below the
// lower bound skips both and loads the error beat. A reseed runs the seed
// sequence and then the warm-up steps (20 by default) and gives no beat.
// One request is in flight at a time; the next request is taken while the
// previous result still waits in the output register.
// ----------------------------------------------------------------------------
module multiply_with_carry_rng import mwc_pkg::*; #(
  parameter int WARMUP_STEPS = 20
) (
  input logic clk,
  input logic rst,
  mwc_req_if.sink   req,
  mwc_rsp_if.source rsp
);

  cmd_t  cmd;
  stat_t stat;
  logic  in_ready;

  assign req.ready = in_ready;

  mwc_ctrl #(
    .WARMUP_STEPS (WARMUP_STEPS)
  ) u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (req.valid),
    .in_ready (in_ready),
    .stat     (stat),
    .cmd      (cmd)
  );

  mwc_datapath u_datapath (
    .clk  (clk),
    .rst  (rst),
    .cmd  (cmd),
    .stat (stat),
    .req  (req),
    .rsp  (rsp)
  );

  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    req.valid && req.ready |=> !req.ready)
    else $error("request accepted while the previous one was in progress");

  a_load_into_free_slot: assert property (@(posedge clk) disable iff (rst)
    cmd.out_load |-> (!rsp.valid || rsp.ready))
    else $error("result loaded over a beat that was not taken");

  a_error_beat_shape: assert property (@(posedge clk) disable iff (rst)
    rsp.valid && rsp.range_error |->
      rsp.range_value == ERROR_VALUE && rsp.raw_word == 32'd0)
    else $error("error beat carries wrong payload");

endmodule

[design/mwc_datapath.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Multiply-with-carry datapath
// Lag and carry registers, one shared 33x32 multiplier with a product
// register, the step accumulator, the seed sequence and the result register.
// ----------------------------------------------------------------------------
module mwc_datapath import mwc_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  cmd_t cmd,
  output stat_t stat,
  mwc_req_if.sink   req,
  mwc_rsp_if.source rsp
);

  logic [31:0] lag [4];
  logic [31:0] carry;
  logic [63:0] acc;
  logic [64:0] prod;
  logic [31:0] s;
  logic [1:0]  mode_r;
  logic [31:0] lo_r;
  logic [32:0] interval;
  logic        bad_r;

  logic [31:0] raw_r;
  logic [31:0] value_r;
  logic        err_r;
  logic        out_valid;

  logic [32:0] mul_a;
  logic [31:0] mul_b;
  logic [64:0] mul_res;
  logic [63:0] step_sum;
  logic [31:0] seed_val;
  logic [31:0] range_sum;

  always_comb begin
    case (cmd.mul_src)
      MSRC_LAG: begin
        mul_a = {1'b0, mul_term(cmd.idx[1:0])};
        mul_b = lag[cmd.idx[1:0]];
      end
      MSRC_SEED: begin
        mul_a = {1'b0, SEED_MUL};
        mul_b = s;
      end
      MSRC_RANGE: begin
        mul_a = interval;
        mul_b = lag[0];
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  assign mul_res   = mul_a * mul_b;
  assign step_sum  = acc + prod[63:0];
  assign seed_val  = prod[31:0] - 32'd1;
  assign range_sum = lo_r + prod[63:32];

  always_ff @(posedge clk) begin
    if (cmd.in_load) begin
      mode_r   <= req.mode;
      s        <= req.seed;
      lo_r     <= req.range_low;
      interval <= {req.range_high[31], req.range_high}
                  - {req.range_low[31], req.range_low} + 33'd1;
      bad_r    <= (req.range_high < req.range_low);
    end else if (cmd.seed_wr) begin
      s <= seed_val;
    end
    if (cmd.mul_en) begin
      prod <= mul_res;
    end
    case (cmd.acc_op)
      ACC_CARRY: acc <= {32'd0, carry};
      ACC_ADD:   acc <= acc + prod[63:0];
      default:   acc <= acc;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      lag[0] <= '0;
      lag[1] <= '0;
      lag[2] <= '0;
      lag[3] <= '0;
      carry  <= '0;
    end else if (cmd.step_commit) begin
      lag[3] <= lag[2];
      lag[2] <= lag[1];
      lag[1] <= lag[0];
      lag[0] <= step_sum[31:0];
      carry  <= step_sum[63:32];
    end else if (cmd.seed_wr) begin
      if (cmd.idx == IDX_LAST) begin
        carry <= seed_val;
      end else begin
        lag[cmd.idx[1:0]] <= seed_val;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      if (mode_r == MODE_RANGE && bad_r) begin
        raw_r   <= '0;
        value_r <= ERROR_VALUE;
        err_r   <= 1'b1;
      end else if (mode_r == MODE_RANGE) begin
        raw_r   <= lag[0];
        value_r <= range_sum;
        err_r   <= 1'b0;
      end else begin
        raw_r   <= lag[0];
        value_r <= '0;
        err_r   <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid <= 1'b1;
    end else if (rsp.ready) begin
      out_valid <= 1'b0;
    end
  end

  assign rsp.valid       = out_valid;
  assign rsp.raw_word    = raw_r;
  assign rsp.range_value = value_r;
  assign rsp.range_error = err_r;

  assign stat.mode      = mode_r;
  assign stat.range_bad = bad_r;
  assign stat.out_free  = !out_valid || rsp.ready;

endmodule

[design/mwc_ctrl.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Multiply-with-carry controller
// Sequences the reseed, warm-up, step and range scaling over the shared
// multiplier and hands each result to the output register.
// ----------------------------------------------------------------------------
module mwc_ctrl import mwc_pkg::*; #(
  parameter int WARMUP_STEPS = 20
) (
  input  logic  clk,
  input  logic  rst,
  input  logic  in_valid,
  output logic  in_ready,
  input  stat_t stat,
  output cmd_t  cmd
);

  localparam int CntW = $clog2(WARMUP_STEPS + 2);

  typedef enum logic [6:0] {
    S_IDLE      = 7'b000_0001,
    S_DISPATCH  = 7'b000_0010,
    S_SEED_MUL  = 7'b000_0100,
    S_SEED_WR   = 7'b000_1000,
    S_STEP      = 7'b001_0000,
    S_RANGE_MUL = 7'b010_0000,
    S_RESULT    = 7'b100_0000
  } state_t;

  state_t          state, state_next;
  logic [2:0]      idx, idx_next;
  logic [CntW-1:0] warm_left, warm_left_next;
  logic            warmup, warmup_next;

  always_comb begin
    state_next     = state;
    idx_next       = idx;
    warm_left_next = warm_left;
    warmup_next    = warmup;
    cmd            = '0;
    cmd.mul_src    = MSRC_LAG;
    cmd.acc_op     = ACC_HOLD;
    cmd.idx        = idx;
    in_ready       = (state == S_IDLE) && !rst;
    cmd.in_load    = in_valid && in_ready;
    case (state)
      S_IDLE: begin
        if (cmd.in_load) begin
          state_next = S_DISPATCH;
        end
      end
      S_DISPATCH: begin
        idx_next    = '0;
        warmup_next = 1'b0;
        case (stat.mode)
          MODE_RESEED: state_next = S_SEED_MUL;
          MODE_RAW:    state_next = S_STEP;
          MODE_RANGE:  state_next = stat.range_bad ? S_RESULT : S_STEP;
          default:     state_next = S_IDLE;
        endcase
      end
      S_SEED_MUL: begin
        cmd.mul_en  = 1'b1;
        cmd.mul_src = MSRC_SEED;
        state_next  = S_SEED_WR;
      end
      S_SEED_WR: begin
        cmd.seed_wr = 1'b1;
        if (idx == IDX_LAST) begin
          idx_next = '0;
          if (WARMUP_STEPS == 0) begin
            state_next = S_IDLE;
          end else begin
            warm_left_next = CntW'(WARMUP_STEPS);
            warmup_next    = 1'b1;
            state_next     = S_STEP;
          end
        end else begin
          idx_next   = idx + 3'd1;
          state_next = S_SEED_MUL;
        end
      end
      S_STEP: begin
        if (idx == IDX_LAST) begin
          cmd.step_commit = 1'b1;
          idx_next        = '0;
          if (warmup) begin
            if (warm_left == CntW'(1)) begin
              warmup_next = 1'b0;
              state_next  = S_IDLE;
            end else begin
              warm_left_next = warm_left - CntW'(1);
            end
          end else if (stat.mode == MODE_RANGE) begin
            state_next = S_RANGE_MUL;
          end else begin
            state_next = S_RESULT;
          end
        end else begin
          cmd.mul_en = 1'b1;
          cmd.acc_op = (idx == 3'd0) ? ACC_CARRY : ACC_ADD;
          idx_next   = idx + 3'd1;
        end
      end
      S_RANGE_MUL: begin
        cmd.mul_en  = 1'b1;
        cmd.mul_src = MSRC_RANGE;
        state_next  = S_RESULT;
      end
      S_RESULT: begin
        if (stat.out_free) begin
          cmd.out_load = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      idx       <= '0;
      warm_left <= '0;
      warmup    <= 1'b0;
    end else begin
      state     <= state_next;
      idx       <= idx_next;
      warm_left <= warm_left_next;
      warmup    <= warmup_next;
    end
  end

endmodule

[tb/mwc_draw_checker.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Multiply-with-carry draw checker
// Watches the request and result channels of the generator. Every accepted
// request runs through a local lag-4 multiply-with-carry model that keeps
// its own lag words and carry. Draws queue the result they must produce, and
// every result beat is compared field by field with the oldest one queued.
// ----------------------------------------------------------------------------
module mwc_draw_checker import mwc_pkg::*; #(
  parameter int WARMUP_STEPS = 20
) (
  input  logic clk,
  input  logic rst,
  mwc_req_if   req,
  mwc_rsp_if   rsp,
  output int   failures,
  output int   outstanding
);

  typedef struct packed {
    logic [31:0]        raw_word;
    logic signed [31:0] range_value;
    logic               range_error;
  } draw_result_t;

  localparam logic [63:0] WEIGHT_OLDEST = 64'd2111111111;
  localparam logic [63:0] WEIGHT_THIRD  = 64'd1492;
  localparam logic [63:0] WEIGHT_SECOND = 64'd1776;
  localparam logic [63:0] WEIGHT_NEWEST = 64'd5115;

  logic [31:0]  lag_word [0:3];
  logic [31:0]  carry_word;
  draw_result_t expected_draws [$];
  int           mismatches;

  assign failures = mismatches;

  function automatic logic [31:0] advance_generator();
    logic [63:0] total;
    total = WEIGHT_OLDEST * {32'd0, lag_word[3]} + WEIGHT_THIRD * {32'd0, lag_word[2]}
          + WEIGHT_SECOND * {32'd0, lag_word[1]} + WEIGHT_NEWEST * {32'd0, lag_word[0]}
          + {32'd0, carry_word};
    lag_word[3] = lag_word[2];
    lag_word[2] = lag_word[1];
    lag_word[1] = lag_word[0];
    lag_word[0] = total[31:0];
    carry_word  = total[63:32];
    return total[31:0];
  endfunction

  function automatic void reseed_generator(input logic [31:0] seed);
    logic [31:0] s;
    logic [31:0] discard;
    s = seed;
    for (int k = 0; k < 4; k++) begin
      s = s * SEED_MUL - 32'd1;
      lag_word[k] = s;
    end
    carry_word = s * SEED_MUL - 32'd1;
    for (int k = 0; k < WARMUP_STEPS; k++) begin
      discard = advance_generator();
    end
  endfunction

  function automatic draw_result_t predict_range_draw(input logic signed [31:0] lo,
                                                      input logic signed [31:0] hi);
    draw_result_t r;
    logic [63:0]  span;
    logic [63:0]  scaled;
    if (hi < lo) begin
      r.raw_word    = 32'd0;
      r.range_value = ERROR_VALUE;
      r.range_error = 1'b1;
    end else begin
      span          = {{32{hi[31]}}, hi} - {{32{lo[31]}}, lo} + 64'd1;
      r.raw_word    = advance_generator();
      scaled        = span * {32'd0, r.raw_word};
      r.range_value = lo + scaled[63:32];
      r.range_error = 1'b0;
    end
    return r;
  endfunction

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    $display("%0t draw check failed on %s: got %h, expected %h", $realtime, what, got,
             want);
    mismatches++;
  endtask

  always @(posedge clk) begin
    draw_result_t got;
    draw_result_t want;
    if (rst) begin
      for (int k = 0; k < 4; k++) begin
        lag_word[k] = 32'd0;
      end
      carry_word = 32'd0;
      expected_draws.delete();
    end else begin
      if (rsp.valid && rsp.ready) begin
        got = '{rsp.raw_word, rsp.range_value, rsp.range_error};
        if (expected_draws.size() == 0) begin
          report_mismatch("result beat with nothing expected", got.raw_word, 32'd0);
        end else begin
          want = expected_draws.pop_front();
          if (got.raw_word !== want.raw_word) begin
            report_mismatch("raw_word", got.raw_word, want.raw_word);
          end
          if (got.range_value !== want.range_value) begin
            report_mismatch("range_value", got.range_value, want.range_value);
          end
          if (got.range_error !== want.range_error) begin
            report_mismatch("range_error", {31'd0, got.range_error}, {31'd0, want.range_error});
          end
        end
      end
      if (req.valid && req.ready) begin
        case (req.mode)
          MODE_RESEED: begin
            reseed_generator(req.seed);
          end
          MODE_RAW: begin
            want.raw_word    = advance_generator();
            want.range_value = 32'sd0;
            want.range_error = 1'b0;
            expected_draws.push_back(want);
          end
          MODE_RANGE: begin
            expected_draws.push_back(predict_range_draw(req.range_low, req.range_high));
          end
          default: begin
          end
        endcase
      end
    end
    outstanding <= expected_draws.size();
  end

endmodule

[tb/tb_multiply_with_carry_rng.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Multiply-with-carry generator testbench
// Drives reseeds, raw draws, range draws with ordered and reversed bounds and
// the unused mode into the generator, with random idle bursts on both
// channels and one long hold on the result side. A checker beside the block
// predicts and compares every result beat; this module gives the verdict.
// ----------------------------------------------------------------------------
module tb_multiply_with_carry_rng;
  import mwc_pkg::*;

  localparam int          WARMUP       = 20;
  localparam int          RANDOM_ITEMS = 630;
  localparam int          CALM_ITEMS   = 80;
  localparam int          HOLD_AT      = 150;
  localparam int          LONG_HOLD    = 80;
  localparam int          TAIL_CYCLES  = 300;
  localparam int          CYCLE_LIMIT  = 200000;
  localparam logic [1:0]  MODE_UNUSED  = 2'd3;
  localparam logic [31:0] INT_MIN      = 32'h8000_0000;
  localparam logic [31:0] INT_MAX      = 32'h7fff_ffff;

  logic clk;
  logic rst;
  bit   calm;
  bit   hold_off;
  int   failures;
  int   outstanding;
  int   cycles;

  mwc_req_if req_ch ();
  mwc_rsp_if rsp_ch ();

  multiply_with_carry_rng #(.WARMUP_STEPS(WARMUP)) uut (
    .clk(clk),
    .rst(rst),
    .req(req_ch),
    .rsp(rsp_ch)
  );

  mwc_draw_checker #(.WARMUP_STEPS(WARMUP)) draw_check (
    .clk(clk),
    .rst(rst),
    .req(req_ch),
    .rsp(rsp_ch),
    .failures(failures),
    .outstanding(outstanding)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  task automatic offer(input logic [1:0] mode, input logic [31:0] seed,
                       input logic [31:0] lo, input logic [31:0] hi);
    if (!calm && $urandom_range(0, 4) == 0) begin
      req_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 3)) @(posedge clk);
    end
    req_ch.valid      <= 1'b1;
    req_ch.mode       <= mode;
    req_ch.seed       <= seed;
    req_ch.range_low  <= lo;
    req_ch.range_high <= hi;
    do @(posedge clk); while (!req_ch.ready);
  endtask

  initial begin
    rsp_ch.ready <= 1'b0;
    repeat (5) @(posedge clk);
    forever begin
      if (hold_off) begin
        rsp_ch.ready <= 1'b0;
        repeat (LONG_HOLD) @(posedge clk);
        hold_off = 1'b0;
      end else if (!calm && $urandom_range(0, 5) == 0) begin
        rsp_ch.ready <= 1'b0;
        repeat ($urandom_range(1, 3)) @(posedge clk);
      end else begin
        rsp_ch.ready <= 1'b1;
        repeat ($urandom_range(1, 8)) @(posedge clk);
      end
    end
  end

  initial begin
    cycles = 0;
    while (cycles < CYCLE_LIMIT) begin
      @(posedge clk);
      cycles++;
    end
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  initial begin
    int          sent;
    int          pick;
    logic [31:0] lo;
    logic [31:0] hi;
    logic [31:0] swap;
    calm              = 1'b0;
    hold_off          = 1'b0;
    rst               <= 1'b1;
    req_ch.valid      <= 1'b0;
    req_ch.mode       <= MODE_RESEED;
    req_ch.seed       <= 32'd0;
    req_ch.range_low  <= 32'd0;
    req_ch.range_high <= 32'd0;
    repeat (5) @(posedge clk);
    rst <= 1'b0;

    // Draws from the all-zero reset state return zero words.
    offer(MODE_RAW, 32'd0, 32'd0, 32'd0);
    offer(MODE_RANGE, 32'd0, -32'sd5, 32'sd5);
    offer(MODE_RANGE, 32'd0, 32'sd10, -32'sd10);
    offer(MODE_RESEED, 32'd0, 32'd0, 32'd0);
    offer(MODE_RAW, 32'd0, 32'd0, 32'd0);
    offer(MODE_RANGE, 32'd0, INT_MIN, INT_MAX);
    offer(MODE_RANGE, 32'd0, 32'sd7, 32'sd7);
    offer(MODE_RANGE, 32'd0, INT_MAX, INT_MAX);
    offer(MODE_RANGE, 32'd0, INT_MIN, INT_MIN);
    offer(MODE_RANGE, 32'd0, INT_MAX, INT_MIN);
    offer(MODE_UNUSED, 32'hffff_ffff, 32'hffff_ffff, 32'hffff_ffff);
    offer(MODE_RAW, 32'hffff_ffff, 32'hffff_ffff, 32'hffff_ffff);
    offer(MODE_RESEED, 32'hffff_ffff, INT_MAX, INT_MIN);
    offer(MODE_RAW, 32'd0, 32'd0, 32'd0);
    offer(MODE_RAW, 32'd0, 32'd0, 32'd0);
    offer(MODE_RANGE, 32'd0, -32'sd1, 32'sd0);
    offer(MODE_RESEED, 32'h8000_0000, 32'd0, 32'd0);
    offer(MODE_RANGE, 32'd0, -32'sd1, -32'sd2);
    offer(MODE_RANGE, 32'd0, 32'sd0, INT_MAX);
    offer(MODE_RAW, 32'd0, 32'd0, 32'd0);

    sent = 0;
    while (sent < RANDOM_ITEMS) begin
      if (sent == HOLD_AT) begin
        hold_off = 1'b1;
      end
      calm = (sent >= RANDOM_ITEMS - CALM_ITEMS);
      pick = $urandom_range(0, 99);
      lo   = $urandom;
      hi   = $urandom;
      if (pick < 6) begin
        offer(MODE_RESEED, $urandom, lo, hi);
        sent++;
      end else if (pick < 9) begin
        offer(MODE_UNUSED, $urandom, lo, hi);
      end else if (pick < 40) begin
        offer(MODE_RAW, $urandom, lo, hi);
        sent++;
      end else begin
        case ($urandom_range(0, 5))
          0: begin
          end
          1: begin
            if ($signed(lo) > $signed(hi)) begin
              swap = lo;
              lo   = hi;
              hi   = swap;
            end
          end
          2: begin
            hi = lo + $urandom_range(0, 1000);
            if ($signed(hi) < $signed(lo)) begin
              hi = INT_MAX;
            end
          end
          3: begin
            lo = $urandom_range(0, 1) ? INT_MIN : lo;
            hi = $urandom_range(0, 1) ? INT_MAX : lo;
          end
          4: begin
            hi = lo;
          end
          default: begin
            if ($signed(lo) < $signed(hi)) begin
              swap = lo;
              lo   = hi;
              hi   = swap;
            end else if (lo == hi) begin
              lo = INT_MAX;
              hi = INT_MIN;
            end
          end
        endcase
        offer(MODE_RANGE, $urandom, lo, hi);
        sent++;
      end
    end
    req_ch.valid <= 1'b0;

    do @(negedge clk); while (outstanding != 0);
    repeat (TAIL_CYCLES) @(posedge clk);
    if (failures == 0 && outstanding == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

[multiply_with_carry_rng.f]
design/mwc_pkg.sv
design/mwc_req_if.sv
design/mwc_rsp_if.sv
design/mwc_datapath.sv
design/mwc_ctrl.sv
design/multiply_with_carry_rng.sv
tb/mwc_draw_checker.sv
tb/tb_multiply_with_carry_rng.sv
